// ----- design/mdic_pkg.sv -----
package mdic_pkg;

	// Fixed port geometry
	localparam int PORT_DIMS = 4;
	localparam int SIZE_W    = 16;
	localparam int IDX_IN_W  = 17;
	localparam int DIMS_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_DIMS    = 4;
	localparam int DEF_INDEX_WIDTH = 16;

	// Register map
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 3'd4;

	// Item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	typedef struct packed {
		logic [PORT_DIMS-1:0][SIZE_W-1:0] size;
		logic [DIMS_W-1:0]                dims;
	} cfg_t;

	typedef struct packed {
		logic [PORT_DIMS-1:0][SIZE_W-1:0] pos;
		logic                             oor;
		logic                             err;
	} result_t;

endpackage

// ----- design/multi_dim_index_counter.sv -----
// Mixed-radix position counter for walking a tensor of up to four dimensions
// (dimension 0 outermost). A load item (mode 0) sets the position from signed
// start indices, negative ones counting back from the dimension size; an index
// below minus its size flags load_error and leaves the position alone. A step
// item (mode 1) bumps the innermost active digit and ripples carries outward;
// stepping past the last element, or from any out-of-range position, parks
// every active digit at its size (end marker). Each item yields one result
// carrying the new position, overrun and load_error. Throughput is one
// item per clock while the result side is drained (out_ready); each item
// passes through the input register, then the result register. The limit
// is the position register feedback: the next position is formed from it
// combinationally. Sizes and dims_in_use are written through the cfg port
// (always ready); the user must write them only while idle, which the
// block itself does not enforce.

module multi_dim_index_counter import mdic_pkg::*; #(
	parameter int MAX_DIMS    = DEF_MAX_DIMS,
	parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DAT_W-1:0]       cfg_data,
	// input items
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic signed [IDX_IN_W-1:0] index_0,
	input  logic signed [IDX_IN_W-1:0] index_1,
	input  logic signed [IDX_IN_W-1:0] index_2,
	input  logic signed [IDX_IN_W-1:0] index_3,
	// result items
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SIZE_W-1:0]          pos_0,
	output logic [SIZE_W-1:0]          pos_1,
	output logic [SIZE_W-1:0]          pos_2,
	output logic [SIZE_W-1:0]          pos_3,
	output logic                       overrun,
	output logic                       load_error
);

	cfg_t                                   cfg;

	// Input stage
	logic                                   valid_s1;
	logic                                   mode_s1;
	logic [PORT_DIMS-1:0][IDX_IN_W-1:0]     index_s1;

	// Counter state
	logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0]   position_q;
	logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0]   pos_nxt;

	// Result stage
	result_t                                res;
	result_t                                res_s2;
	logic                                   valid_s2;

	logic                                   advance;
	logic                                   in_acc;

	mdic_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register moves whenever it is empty or being drained; the
	// input register can then refill in the same cycle.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1     <= mode;
			index_s1[0] <= index_0;
			index_s1[1] <= index_1;
			index_s1[2] <= index_2;
			index_s1[3] <= index_3;
		end
	end

	mdic_next_pos #(
		.MAX_DIMS    (MAX_DIMS),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_next (
		.cfg     (cfg),
		.mode    (mode_s1),
		.index   (index_s1),
		.pos_cur (position_q),
		.pos_nxt (pos_nxt),
		.res     (res)
	);

	// Position updates exactly when its item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			valid_s2   <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				position_q <= pos_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign pos_0      = res_s2.pos[0];
	assign pos_1      = res_s2.pos[1];
	assign pos_2      = res_s2.pos[2];
	assign pos_3      = res_s2.pos[3];
	assign overrun    = res_s2.oor;
	assign load_error = res_s2.err;

endmodule

// ----- design/mdic_cfg_regs.sv -----
module mdic_cfg_regs import mdic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_DIMS; i++) begin
				cfg_q.size[i] <= SIZE_W'(1);
			end
			cfg_q.dims <= DIMS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIZE_0: begin
					cfg_q.size[0] <= cfg_data[SIZE_W-1:0];
				end
				CFG_SIZE_1: begin
					cfg_q.size[1] <= cfg_data[SIZE_W-1:0];
				end
				CFG_SIZE_2: begin
					cfg_q.size[2] <= cfg_data[SIZE_W-1:0];
				end
				CFG_SIZE_3: begin
					cfg_q.size[3] <= cfg_data[SIZE_W-1:0];
				end
				CFG_DIMS: begin
					cfg_q.dims <= cfg_data[DIMS_W-1:0];
				end
				default: begin
					// unmapped index: ignored
				end
			endcase
		end
	end

endmodule

// ----- design/mdic_next_pos.sv -----
module mdic_next_pos import mdic_pkg::*; #(
	parameter int MAX_DIMS    = DEF_MAX_DIMS,
	parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
	input  cfg_t                                     cfg,
	input  logic                                     mode,
	input  logic [PORT_DIMS-1:0][IDX_IN_W-1:0]       index,
	input  logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0]     pos_cur,
	output logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0]     pos_nxt,
	output result_t                                  res
);

	localparam int LIM = (MAX_DIMS < PORT_DIMS) ? MAX_DIMS : PORT_DIMS;
	localparam int SW  = (INDEX_WIDTH > SIZE_W) ? INDEX_WIDTH : SIZE_W;
	localparam logic [DIMS_W-1:0] LIM_V = DIMS_W'(LIM);

	logic [DIMS_W-1:0]                  n_act;
	logic [MAX_DIMS-1:0]                act;
	logic [MAX_DIMS-1:0]                wrap;
	logic [MAX_DIMS-1:0]                carry;
	logic [MAX_DIMS-1:0]                is_out;
	logic [MAX_DIMS-1:0]                ld_bad;
	logic [MAX_DIMS-1:0]                nxt_out;
	logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0] dsz;
	logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0] ld_val;
	logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0] stepped;
	logic                               at_end;
	logic                               ld_err;

	// Active dimension count, clamped to 1..LIM
	always_comb begin
		if (cfg.dims == '0) begin
			n_act = DIMS_W'(1);
		end else if (cfg.dims > LIM_V) begin
			n_act = LIM_V;
		end else begin
			n_act = cfg.dims;
		end
	end

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dig
		logic [SIZE_W-1:0]      size_raw;
		logic [IDX_IN_W-1:0]    idx_raw;
		logic [SW-1:0]          sz_wide;
		logic [SW-1:0]          sz_back;
		logic [SIZE_W-1:0]      sz16;
		logic [IDX_IN_W:0]      sum;
		logic [SIZE_W-1:0]      ld16;
		logic [SW-1:0]          ld_wide;
		logic [INDEX_WIDTH:0]   inc;

		if (d < PORT_DIMS) begin : g_port
			assign size_raw = cfg.size[d];
			assign idx_raw  = index[d];
		end else begin : g_noport
			assign size_raw = '0;
			assign idx_raw  = '0;
		end

		assign act[d] = (DIMS_W'(d) < n_act);

		// Size seen at digit width, and back at port width for the load add
		assign sz_wide = SW'(size_raw);
		assign dsz[d]  = sz_wide[INDEX_WIDTH-1:0];
		assign sz_back = SW'(dsz[d]);
		assign sz16    = sz_back[SIZE_W-1:0];

		// Negative index counts back from the size
		assign sum       = {2'b00, sz16} + {idx_raw[IDX_IN_W-1], idx_raw};
		assign ld_bad[d] = act[d] & idx_raw[IDX_IN_W-1] & sum[IDX_IN_W];
		assign ld16      = idx_raw[IDX_IN_W-1] ? sum[SIZE_W-1:0] : idx_raw[SIZE_W-1:0];
		assign ld_wide   = SW'(ld16);
		assign ld_val[d] = ld_wide[INDEX_WIDTH-1:0];

		// Increment with wrap at size
		assign inc        = {1'b0, pos_cur[d]} + (INDEX_WIDTH+1)'(1);
		assign wrap[d]    = (inc == {1'b0, dsz[d]});
		assign stepped[d] = !carry[d] ? pos_cur[d] :
			(wrap[d] ? '0 : inc[INDEX_WIDTH-1:0]);
		assign is_out[d]  = act[d] & (pos_cur[d] >= dsz[d]);
	end

	// Carry enters at the innermost active digit and ripples outward
	always_comb begin
		carry[MAX_DIMS-1] = 1'b1;
		for (int d = MAX_DIMS - 2; d >= 0; d--) begin
			carry[d] = act[d+1] ? (carry[d+1] & wrap[d+1]) : 1'b1;
		end
	end

	assign at_end = (|is_out) | (carry[0] & wrap[0]);
	assign ld_err = (mode == MODE_LOAD) & (|ld_bad);

	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (mode == MODE_LOAD) begin
				if (ld_err) begin
					pos_nxt[d] = pos_cur[d];
				end else begin
					pos_nxt[d] = act[d] ? ld_val[d] : '0;
				end
			end else begin
				if (!act[d]) begin
					pos_nxt[d] = '0;
				end else if (at_end) begin
					pos_nxt[d] = dsz[d];
				end else begin
					pos_nxt[d] = stepped[d];
				end
			end
			nxt_out[d] = act[d] & (pos_nxt[d] >= dsz[d]);
		end
	end

	for (genvar k = 0; k < PORT_DIMS; k++) begin : g_out
		if (k < MAX_DIMS) begin : g_dig_out
			logic [SW-1:0] pw;
			assign pw         = SW'(pos_nxt[k]);
			assign res.pos[k] = act[k] ? pw[SIZE_W-1:0] : '0;
		end else begin : g_zero_out
			assign res.pos[k] = '0;
		end
	end

	assign res.oor = |nxt_out;
	assign res.err = ld_err;

endmodule

// ----- dv/tb_multi_dim_index_counter.sv -----
`timescale 1ns / 1ps

module tb_multi_dim_index_counter;
	import mdic_pkg::*;

	// Expected-result tracker: mirrors the size registers and the position digits,
	// and holds one predicted result per accepted item until it comes out.
	class pos_scoreboard;
		logic [SIZE_W-1:0] extent [PORT_DIMS];
		logic [DIMS_W-1:0] dims_reg;
		logic [SIZE_W-1:0] digit [PORT_DIMS];
		result_t           pending_q [$];
		int                mismatches;
		int                loads;
		int                steps;
		int                load_errors;
		int                end_hits;

		function new();
			for (int d = 0; d < PORT_DIMS; d++) begin
				extent[d] = 1;
				digit[d]  = '0;
			end
			dims_reg    = 1;
			mismatches  = 0;
			loads       = 0;
			steps       = 0;
			load_errors = 0;
			end_hits    = 0;
		endfunction

		function int live_dims();
			if (dims_reg == 0)
				return 1;
			if (dims_reg > PORT_DIMS)
				return PORT_DIMS;
			return dims_reg;
		endfunction

		function bit beyond(int n);
			for (int d = 0; d < n; d++)
				if (digit[d] >= extent[d])
					return 1;
			return 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				CFG_SIZE_0: extent[0] = data;
				CFG_SIZE_1: extent[1] = data;
				CFG_SIZE_2: extent[2] = data;
				CFG_SIZE_3: extent[3] = data;
				CFG_DIMS:   dims_reg  = data[DIMS_W-1:0];
				default:    ;
			endcase
		endfunction

		// Accepted input item: update the position and queue the result.
		function void note_item(logic md, logic [PORT_DIMS-1:0][IDX_IN_W-1:0] ix);
			int                n;
			int                idx;
			int                sz;
			bit                err;
			bit                wrapped;
			logic [SIZE_W-1:0] fresh [PORT_DIMS];
			result_t           want;
			n   = live_dims();
			err = 0;
			if (md == MODE_LOAD) begin
				loads++;
				for (int d = 0; d < n; d++) begin
					idx = int'($signed(ix[d]));
					sz  = int'(extent[d]);
					if (idx < 0 && idx + sz < 0)
						err = 1;
					else if (idx < 0)
						fresh[d] = SIZE_W'(sz + idx);
					else
						fresh[d] = SIZE_W'(idx);
				end
				// a rejected load keeps every digit, inactive ones too
				if (!err) begin
					for (int d = 0; d < PORT_DIMS; d++)
						digit[d] = (d < n) ? fresh[d] : '0;
				end else begin
					load_errors++;
				end
			end else begin
				steps++;
				for (int d = n; d < PORT_DIMS; d++)
					digit[d] = '0;
				wrapped = 1;
				if (!beyond(n)) begin
					for (int d = n - 1; d >= 0 && wrapped; d--) begin
						if (int'(digit[d]) + 1 < int'(extent[d])) begin
							digit[d] = digit[d] + 1'b1;
							wrapped  = 0;
						end else begin
							digit[d] = '0;
						end
					end
				end
				if (wrapped) begin
					for (int d = 0; d < n; d++)
						digit[d] = extent[d];
				end
			end
			for (int d = 0; d < PORT_DIMS; d++)
				want.pos[d] = (d < n) ? digit[d] : '0;
			want.oor = beyond(n);
			want.err = err;
			if (md == MODE_STEP && want.oor)
				end_hits++;
			pending_q.push_back(want);
		endfunction

		function void report(string what, result_t want, result_t got);
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t: %s: exp pos %0d %0d %0d %0d oor %0b err %0b,",
					" got pos %0d %0d %0d %0d oor %0b err %0b"},
					$time, what, want.pos[0], want.pos[1], want.pos[2], want.pos[3], want.oor,
					want.err, got.pos[0], got.pos[1], got.pos[2], got.pos[3], got.oor, got.err);
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit      bad;
			if (pending_q.size() == 0) begin
				report("result with nothing pending", got, got);
				return;
			end
			want = pending_q.pop_front();
			bad  = (got.oor !== want.oor) || (got.err !== want.err);
			for (int d = 0; d < PORT_DIMS; d++)
				if (got.pos[d] !== want.pos[d])
					bad = 1;
			if (bad)
				report("result mismatch", want, got);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 mode      = MODE_LOAD;
	logic [IDX_IN_W-1:0]  index_0   = '0;
	logic [IDX_IN_W-1:0]  index_1   = '0;
	logic [IDX_IN_W-1:0]  index_2   = '0;
	logic [IDX_IN_W-1:0]  index_3   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b1;
	logic [SIZE_W-1:0]    pos_0;
	logic [SIZE_W-1:0]    pos_1;
	logic [SIZE_W-1:0]    pos_2;
	logic [SIZE_W-1:0]    pos_3;
	logic                 overrun;
	logic                 load_error;

	pos_scoreboard sb;
	result_t       seen;
	int            idle_pct  = 0;   // chance of an idle burst per item / per cycle
	int            stall_left = 0;
	int            shapes    = 0;

	multi_dim_index_counter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.index_0    (index_0),
		.index_1    (index_1),
		.index_2    (index_2),
		.index_3    (index_3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pos_0      (pos_0),
		.pos_1      (pos_1),
		.pos_2      (pos_2),
		.pos_3      (pos_3),
		.overrun    (overrun),
		.load_error (load_error)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Monitor: every handshake is sampled at the rising edge, before the
	// block's own updates land. Items are noted before results are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_item(mode, {index_3, index_2, index_1, index_0});
			if (out_valid && out_ready) begin
				seen.pos[0] = pos_0;
				seen.pos[1] = pos_1;
				seen.pos[2] = pos_2;
				seen.pos[3] = pos_3;
				seen.oor    = overrun;
				seen.err    = load_error;
				sb.check_result(seen);
			end
		end
	end

	// Result-side backpressure: random stall bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready  = 1'b0;
			stall_left = stall_left - 1;
		end else if (int'($urandom_range(0, 99)) < idle_pct) begin
			out_ready  = 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_ready = 1'b1;
		end
	end

	// Present one item, possibly after an idle burst, and hold it until taken.
	task automatic send_item(input logic md, input logic [PORT_DIMS-1:0][IDX_IN_W-1:0] ix);
		int gap;
		gap = (int'($urandom_range(0, 99)) < idle_pct) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		mode     = md;
		index_0  = ix[0];
		index_1  = ix[1];
		index_2  = ix[2];
		index_3  = ix[3];
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_at(input int i0, input int i1, input int i2, input int i3);
		send_item(MODE_LOAD, {IDX_IN_W'(i3), IDX_IN_W'(i2), IDX_IN_W'(i1), IDX_IN_W'(i0)});
	endtask

	// index fields carry junk on a step; the block must ignore them
	task automatic step_once();
		send_item(MODE_STEP, {IDX_IN_W'($urandom), IDX_IN_W'($urandom),
			IDX_IN_W'($urandom), IDX_IN_W'($urandom)});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drop valid, wait for every pending result, then let the pipe empty out.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Reprogram all five registers while idle; now and then also poke an
	// address past the register map, which must be a no-op.
	task automatic apply_shape(input int s0, input int s1, input int s2, input int s3,
			input int dims);
		settle();
		write_reg(CFG_SIZE_0, CFG_DAT_W'(s0));
		write_reg(CFG_SIZE_1, CFG_DAT_W'(s1));
		write_reg(CFG_SIZE_2, CFG_DAT_W'(s2));
		write_reg(CFG_SIZE_3, CFG_DAT_W'(s3));
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_DIMS + CFG_IDX_W'($urandom_range(1, 3)), CFG_DAT_W'($urandom));
		// upper data bits are don't-care for the dims register
		write_reg(CFG_DIMS, {CFG_DAT_W'($urandom) & ~CFG_DAT_W'(7)} | CFG_DAT_W'(dims));
		shapes++;
	endtask

	function automatic int rand_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return 65535;
		if (r == 2)
			return $urandom_range(0, 65535);
		return $urandom_range(1, 6);
	endfunction

	// Legal start index, biased toward the last few elements so that steps
	// soon carry; returned in positive or negative form at random.
	function automatic int start_index(int sz);
		int at;
		int span;
		if (sz == 0)
			return 0;
		span = (sz > 3) ? 2 : sz - 1;
		if ($urandom_range(0, 2) == 0)
			at = $urandom_range(0, sz - 1);
		else
			at = sz - 1 - int'($urandom_range(0, span));
		return $urandom_range(0, 1) ? at : at - sz;
	endfunction

	// Anything the field allows: raw bits, rejected negatives, indexes at or
	// past the size, or a legal one.
	function automatic int odd_index(int sz);
		case ($urandom_range(0, 3))
			0:       return int'($signed(IDX_IN_W'($urandom)));
			1:       return -sz - 1 - int'($urandom_range(0, 65535 - sz));
			2:       return sz + int'($urandom_range(0, 65535 - sz));
			default: return start_index(sz);
		endcase
	endfunction

	// Mostly a load followed by a run of steps; the rest single odd items.
	task automatic run_random(input int count);
		int                                 left;
		int                                 n;
		int                                 len;
		bit                                 clean;
		logic [PORT_DIMS-1:0][IDX_IN_W-1:0] ix;
		left = count;
		while (left > 0) begin
			n     = sb.live_dims();
			clean = ($urandom_range(0, 9) < 7);
			if (clean || $urandom_range(0, 1)) begin
				for (int d = 0; d < PORT_DIMS; d++) begin
					if (d >= n)
						ix[d] = IDX_IN_W'($urandom);
					else if (clean)
						ix[d] = IDX_IN_W'(start_index(int'(sb.extent[d])));
					else
						ix[d] = IDX_IN_W'(odd_index(int'(sb.extent[d])));
				end
				send_item(MODE_LOAD, ix);
			end else begin
				step_once();
			end
			left--;
			if (clean) begin
				len = $urandom_range(1, 16);
				while (len > 0 && left > 0) begin
					step_once();
					len--;
					left--;
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		// small 4-D tensor: walk, carry, last element, end marker, exact minus
		// size, one below it, index past size, most negative index
		idle_pct = 15;
		apply_shape(2, 3, 2, 4, 4);
		load_at(0, 0, 0, 0);
		repeat (3) step_once();
		step_once();
		load_at(-1, -1, -1, -1);
		step_once();
		step_once();
		load_at(-2, -3, -2, -4);
		load_at(0, 0, 0, -5);
		load_at(65535, 0, 0, 0);
		step_once();
		load_at(-65536, 0, 0, 0);
		load_at(0, 2, 1, 3);
		step_once();

		// largest size next to a zero size: always out of range
		apply_shape(65535, 0, 1, 1, 2);
		load_at(65534, 0, 0, 0);
		step_once();
		load_at(-65535, -1, 0, 0);

		// dims of zero behaves as one dimension
		apply_shape(65535, 3, 3, 3, 0);
		load_at(65534, 1, 1, 1);
		step_once();
		load_at(-65535, 2, 2, 2);

		// dims past the maximum behaves as four, all sizes at the top
		apply_shape(65535, 65535, 65535, 65535, 7);
		load_at(-1, -1, -1, -1);
		step_once();
		load_at(65535, 65535, 65535, 65535);
		step_once();

		// --- random phases ---
		// first two pin the size extremes; idling varies per phase with some
		// phases quiet, and the final phase runs at full rate
		for (int ph = 0; ph < 12; ph++) begin
			idle_pct = (ph == 11 || ph % 4 == 3) ? 0 : ((ph % 2) ? 30 : 12);
			if (ph == 0)
				apply_shape(65535, 65535, 65535, 65535, 4);
			else if (ph == 1)
				apply_shape(1, 1, 1, 1, 4);
			else
				apply_shape(rand_size(), rand_size(), rand_size(), rand_size(),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
						: $urandom_range(1, 4));
			run_random(150);
		end

		settle();
		$display("covered %0d loads (%0d rejected) and %0d steps (%0d at end marker)",
			sb.loads, sb.load_errors, sb.steps, sb.end_hits);
		$display("across %0d register settings", shapes);
		if (sb.pending_q.size() != 0)
			$display("%0d results never arrived", sb.pending_q.size());
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("[multi_dim_index_counter] OK");
		else
			$display("[multi_dim_index_counter] ERROR");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#400000;
		$display("timeout with %0d results pending", sb.pending_q.size());
		$display("[multi_dim_index_counter] ERROR");
		$finish;
	end

endmodule
